/* rtl/edp_pkg.sv */
// Shared types and constants for the Elias delta bit packer.
// Used by every module of the block; depends on nothing else.
package edp_pkg;

    // Fixed field widths of the request and result items.
    localparam int VALUE_W    = 32;
    localparam int COUNT_W    = 6;
    localparam int RES_WORD_W = 32;

    // The longest Elias delta code of a 32-bit value plus one is 42 bits.
    localparam int CODE_BITS  = 42;
    localparam int CODE_LEN_W = 6;

    // The raw command writes at most this many bits.
    localparam logic [COUNT_W-1:0] RAW_MAX_BITS = 6'd32;

    // Command codes. The last one is not used and is ignored by the block.
    localparam logic [1:0] CMD_ENCODE = 2'd0;
    localparam logic [1:0] CMD_RAW    = 2'd1;
    localparam logic [1:0] CMD_FLUSH  = 2'd2;
    localparam logic [1:0] CMD_UNUSED = 2'd3;

    // Kinds of work passed from the front end to the packer.
    localparam logic [1:0] KIND_BITS  = 2'd0;
    localparam logic [1:0] KIND_FLUSH = 2'd1;
    localparam logic [1:0] KIND_ERROR = 2'd2;

    // Work queue size.
    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);

    typedef struct packed {
        logic [1:0]         command;
        logic [VALUE_W-1:0] value;
        logic [COUNT_W-1:0] bit_count;
    } req_item_t;

    typedef struct packed {
        logic [RES_WORD_W-1:0] word;
        logic                  last;
        logic                  error;
    } res_item_t;

    // One unit of work: a right-aligned run of bits, a flush or an error.
    typedef struct packed {
        logic [1:0]            kind;
        logic [CODE_BITS-1:0]  code;
        logic [CODE_LEN_W-1:0] len;
    } work_t;

endpackage

/* rtl/elias_delta_bit_packer_top.sv */
// Top level of the Elias delta bit packer.
// Depends on edp_pkg, edp_front, edp_queue and edp_back.

// The block packs a bit stream, first bit first, into WORD_BITS-bit words whose
// first bit lands in the most significant bit; the result word field carries
// the low 32 bits of a word. Each request is one of three commands: encode
// writes the Elias delta code of value plus one (at most 42 bits), raw writes
// the low bit_count bits of value (a count above 32 counts as 32, a count of
// zero writes nothing), and flush sends out the partial word padded with zeros
// and empties the store. A full word is held until further bits arrive or a
// flush comes, so a request yields zero, one or more results, and the last of
// them carries last. Encoding 4294967295 would overflow the code; it yields one
// result with error and last set and word zero, and leaves the store as it was.
// The front end classifies a request and builds its code in the cycle it is
// accepted and places it in a four-entry work queue; the packer behind the
// queue works on one unit of work at a time and sends at most one word per
// cycle into a result register, only while it is free. Raw requests with a
// zero count and the unused command never enter the queue; a flush of an
// empty store sends nothing. At the default word size the block sustains one
// request per cycle while results are not stalled, except where a code crosses
// two word boundaries and goes out as two words. Request stall rises only when
// the queue is full; a stalled result register holds the packer only when it
// has a word to send, and never blocks request acceptance directly.
module elias_delta_bit_packer_top
#(
    parameter int WORD_BITS = 32
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               cmd_valid,
    output logic               cmd_stall,
    input  edp_pkg::req_item_t cmd,
    output logic               res_valid,
    input  logic               res_stall,
    output edp_pkg::res_item_t res
);

    logic           push;
    edp_pkg::work_t push_work;
    logic           queue_full;
    logic           head_valid;
    edp_pkg::work_t head;
    logic           pop;

    edp_front u_front
    (
        .req_valid  (cmd_valid),
        .req        (cmd),
        .queue_full (queue_full),
        .req_stall  (cmd_stall),
        .push       (push),
        .work       (push_work)
    );

    edp_queue u_queue
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .push_work  (push_work),
        .pop        (pop),
        .full       (queue_full),
        .head_valid (head_valid),
        .head       (head)
    );

    edp_back
    #(
        .WORD_BITS (WORD_BITS)
    )
    u_back
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .head_valid (head_valid),
        .head       (head),
        .pop        (pop),
        .res_valid  (res_valid),
        .res_stall  (res_stall),
        .res        (res)
    );

endmodule

/* rtl/edp_front.sv */
// Front end of the Elias delta bit packer: accepts requests and turns each
// into a run of code bits, a flush or an error. Depends on edp_pkg.
module edp_front
(
    input  logic              req_valid,
    input  edp_pkg::req_item_t req,
    input  logic              queue_full,
    output logic              req_stall,
    output logic              push,
    output edp_pkg::work_t    work
);

    logic [edp_pkg::VALUE_W-1:0]    n_val;
    logic [edp_pkg::CODE_LEN_W-1:0] nb;
    logic [2:0]                     lb;
    logic [edp_pkg::COUNT_W-1:0]    raw_cnt;
    logic [edp_pkg::VALUE_W-1:0]    raw_mask;
    logic                           overflow;
    logic                           drop;

    assign req_stall = queue_full;

    // Leading-one detection on value plus one, then on its bit length.
    always_comb
    begin
        n_val = req.value + 32'd1;
        nb    = '0;
        for (int i = 0; i < edp_pkg::VALUE_W; i++)
        begin
            if (n_val[i])
            begin
                nb = edp_pkg::CODE_LEN_W'(i + 1);
            end
        end
        lb = '0;
        for (int i = 0; i < edp_pkg::CODE_LEN_W; i++)
        begin
            if (nb[i])
            begin
                lb = 3'(i + 1);
            end
        end
    end

    always_comb
    begin
        raw_cnt  = (req.bit_count > edp_pkg::RAW_MAX_BITS) ? edp_pkg::RAW_MAX_BITS
                                                          : req.bit_count;
        raw_mask = ~({edp_pkg::VALUE_W{1'b1}} << raw_cnt);
        overflow = (req.value == {edp_pkg::VALUE_W{1'b1}});
        drop     = 1'b0;
        work     = '0;
        unique case (req.command)
            edp_pkg::CMD_ENCODE:
            begin
                if (overflow)
                begin
                    work.kind = edp_pkg::KIND_ERROR;
                end
                else
                begin
                    // The leading zeros are implied by the right-aligned length.
                    work.kind = edp_pkg::KIND_BITS;
                    work.code = (edp_pkg::CODE_BITS'(nb) << (nb - 6'd1))
                              | (edp_pkg::CODE_BITS'(n_val)
                                 & ~(edp_pkg::CODE_BITS'(1) << (nb - 6'd1)));
                    work.len  = edp_pkg::CODE_LEN_W'({lb - 3'd1, 1'b0}) + nb;
                end
            end
            edp_pkg::CMD_RAW:
            begin
                work.kind = edp_pkg::KIND_BITS;
                work.code = edp_pkg::CODE_BITS'(req.value & raw_mask);
                work.len  = raw_cnt;
                drop      = (raw_cnt == '0);
            end
            edp_pkg::CMD_FLUSH:
            begin
                work.kind = edp_pkg::KIND_FLUSH;
            end
            default:
            begin
                drop = 1'b1;
            end
        endcase
    end

    assign push = req_valid && !queue_full && !drop;

endmodule

/* rtl/edp_queue.sv */
// Short work queue between the front end and the packer.
// Depends on edp_pkg.
module edp_queue
(
    input  logic           clk,
    input  logic           rst_n,
    input  logic           push,
    input  edp_pkg::work_t push_work,
    input  logic           pop,
    output logic           full,
    output logic           head_valid,
    output edp_pkg::work_t head
);

    edp_pkg::work_t                slot_reg [edp_pkg::QUEUE_DEPTH];
    logic [edp_pkg::QPTR_W-1:0]    wr_ptr_reg, wr_ptr_next;
    logic [edp_pkg::QPTR_W-1:0]    rd_ptr_reg, rd_ptr_next;
    logic [edp_pkg::QPTR_W:0]      fill_reg, fill_next;
    logic                          do_pop;

    assign full       = (fill_reg == (edp_pkg::QPTR_W + 1)'(edp_pkg::QUEUE_DEPTH));
    assign head_valid = (fill_reg != '0);
    assign head       = slot_reg[rd_ptr_reg];
    assign do_pop     = pop && head_valid;

    always_comb
    begin
        wr_ptr_next = push ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = do_pop ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        fill_next   = fill_reg + (edp_pkg::QPTR_W + 1)'(push)
                    - (edp_pkg::QPTR_W + 1)'(do_pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            fill_reg   <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            fill_reg   <= fill_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slot_reg[wr_ptr_reg] <= push_work;
        end
    end

endmodule

/* rtl/edp_back.sv */
// Packer of the Elias delta bit packer: appends work bits to the word store
// and emits completed words through a result register. Depends on edp_pkg.
module edp_back
#(
    parameter int WORD_BITS = 32
)
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              head_valid,
    input  edp_pkg::work_t    head,
    output logic              pop,
    output logic              res_valid,
    input  logic              res_stall,
    output edp_pkg::res_item_t res
);

    localparam int CNT_W = $clog2(WORD_BITS + 1);
    localparam int CW    = WORD_BITS + edp_pkg::CODE_BITS;
    localparam int SH_W  = $clog2(CW + 1);

    logic [WORD_BITS-1:0]              pending_reg, pending_next;
    logic [CNT_W-1:0]                  count_reg, count_next;
    logic                              resid_valid_reg, resid_valid_next;
    logic [edp_pkg::CODE_LEN_W-1:0]    resid_len_reg, resid_len_next;
    logic [edp_pkg::CODE_BITS-1:0]     resid_code_reg, resid_code_next;
    logic                              res_valid_reg, res_valid_next;
    edp_pkg::res_item_t                res_reg, res_next;

    logic [edp_pkg::CODE_LEN_W-1:0]    r_len;
    logic [edp_pkg::CODE_BITS-1:0]     code;
    logic [SH_W-1:0]                   room, total, rem;
    logic [edp_pkg::CODE_LEN_W-1:0]    rem_len;
    logic [edp_pkg::CODE_BITS-1:0]     code_rem;
    logic [CW-1:0]                     pend_ext, code_ext;
    logic [CW-1:0]                     fill_word, append_word, flush_word;
    logic                              out_free;

    always_comb
    begin
        r_len     = resid_valid_reg ? resid_len_reg : head.len;
        code      = resid_valid_reg ? resid_code_reg : head.code;
        room      = SH_W'(WORD_BITS) - SH_W'(count_reg);
        total     = SH_W'(count_reg) + SH_W'(r_len);
        rem       = SH_W'(r_len) - room;
        rem_len   = edp_pkg::CODE_LEN_W'(rem);
        code_rem  = code & ~({edp_pkg::CODE_BITS{1'b1}} << rem_len);
        pend_ext  = CW'(pending_reg);
        code_ext  = CW'(code);
        fill_word   = (pend_ext << room) | (code_ext >> rem);
        append_word = (pend_ext << r_len) | code_ext;
        flush_word  = pend_ext << room;
        out_free    = !res_valid_reg || !res_stall;
    end

    always_comb
    begin
        pop              = 1'b0;
        pending_next     = pending_reg;
        count_next       = count_reg;
        resid_valid_next = resid_valid_reg;
        resid_len_next   = resid_len_reg;
        resid_code_next  = resid_code_reg;
        res_valid_next   = res_valid_reg && res_stall;
        res_next         = res_reg;
        if (head_valid)
        begin
            unique case (head.kind)
                edp_pkg::KIND_BITS:
                begin
                    if (total > SH_W'(WORD_BITS))
                    begin
                        // The store fills and bits remain: a word goes out.
                        if (out_free)
                        begin
                            res_valid_next = 1'b1;
                            res_next.word  = edp_pkg::RES_WORD_W'(fill_word[WORD_BITS-1:0]);
                            res_next.error = 1'b0;
                            res_next.last  = (rem <= SH_W'(WORD_BITS));
                            if (rem <= SH_W'(WORD_BITS))
                            begin
                                pending_next     = WORD_BITS'(CW'(code_rem));
                                count_next       = CNT_W'(rem);
                                resid_valid_next = 1'b0;
                                pop              = 1'b1;
                            end
                            else
                            begin
                                pending_next     = '0;
                                count_next       = '0;
                                resid_valid_next = 1'b1;
                                resid_len_next   = rem_len;
                                resid_code_next  = code_rem;
                            end
                        end
                    end
                    else
                    begin
                        pending_next     = append_word[WORD_BITS-1:0];
                        count_next       = CNT_W'(total);
                        resid_valid_next = 1'b0;
                        pop              = 1'b1;
                    end
                end
                edp_pkg::KIND_FLUSH:
                begin
                    if (count_reg == '0)
                    begin
                        pop = 1'b1;
                    end
                    else if (out_free)
                    begin
                        res_valid_next = 1'b1;
                        res_next.word  = edp_pkg::RES_WORD_W'(flush_word[WORD_BITS-1:0]);
                        res_next.error = 1'b0;
                        res_next.last  = 1'b1;
                        pending_next   = '0;
                        count_next     = '0;
                        pop            = 1'b1;
                    end
                end
                edp_pkg::KIND_ERROR:
                begin
                    if (out_free)
                    begin
                        res_valid_next = 1'b1;
                        res_next.word  = '0;
                        res_next.error = 1'b1;
                        res_next.last  = 1'b1;
                        pop            = 1'b1;
                    end
                end
                default:
                begin
                    pop = 1'b1;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pending_reg     <= '0;
            count_reg       <= '0;
            resid_valid_reg <= 1'b0;
            res_valid_reg   <= 1'b0;
        end
        else
        begin
            pending_reg     <= pending_next;
            count_reg       <= count_next;
            resid_valid_reg <= resid_valid_next;
            res_valid_reg   <= res_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        resid_len_reg  <= resid_len_next;
        resid_code_reg <= resid_code_next;
        res_reg        <= res_next;
    end

    assign res_valid = res_valid_reg;
    assign res       = res_reg;

endmodule

/* rtl/edp_checker.sv */
// Port-level checker for the Elias delta bit packer and its bind statement.
// Depends on edp_pkg and elias_delta_bit_packer_top.
module edp_checker
(
    input logic               clk,
    input logic               rst_n,
    input logic               cmd_stall,
    input logic               res_valid,
    input logic               res_stall,
    input edp_pkg::res_item_t res
);

    // A result held back by the consumer stays offered and unchanged.
    assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && res_stall |=> res_valid && $stable(res))
        else $error("stalled result changed or dropped");

    // An overflow result is a single, final result with a zero word.
    assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && res.error |-> res.last && (res.word == '0))
        else $error("error result without last or with nonzero word");

    // Coming out of reset the block is empty and takes requests at once.
    assert property (@(posedge clk)
        $rose(rst_n) |-> !res_valid && !cmd_stall)
        else $error("block not empty after reset");

    // The handshake outputs are always known once reset is released.
    assert property (@(posedge clk) disable iff (!rst_n)
        !$isunknown({res_valid, cmd_stall}))
        else $error("unknown value on a handshake output");

endmodule

bind elias_delta_bit_packer_top edp_checker u_edp_checker (.*);

/* test/testbench.sv */
// Self-checking testbench for elias_delta_bit_packer_top.
// Holds the request driver, the result stall generator and a scoreboard that predicts
// every packed word; depends only on edp_pkg and the block's RTL.
`timescale 1ns / 100ps

module testbench;

    // The block runs at its default word size, so the prediction packs 32-bit words.
    localparam int WORD_W       = edp_pkg::RES_WORD_W;
    localparam int REQ_W        = $bits(edp_pkg::req_item_t);
    localparam int CYCLE_LIMIT  = 1_000_000;
    localparam int HOLD_CYCLES  = 400;
    localparam int DRAIN_CYCLES = 20;

    // The scoreboard keeps its own copy of the packing store. Each accepted request
    // appends its bits to that store, and every word that the store hands out
    // becomes an expected result. Observed results are checked in order.
    class word_scoreboard;
        edp_pkg::res_item_t expected_words[$];
        logic [WORD_W-1:0]  store_bits;
        int unsigned        store_count;
        int unsigned        mismatches;
        int unsigned        words_checked;
        int unsigned        overflows_checked;
        int unsigned        encode_count;
        int unsigned        raw_count;
        int unsigned        flush_count;
        int unsigned        ignored_count;

        function new();
            store_bits        = '0;
            store_count       = 0;
            mismatches        = 0;
            words_checked     = 0;
            overflows_checked = 0;
            encode_count      = 0;
            raw_count         = 0;
            flush_count       = 0;
            ignored_count     = 0;
        endfunction

        function int unsigned bit_len(logic [31:0] x);
            int unsigned n;
            n = 0;
            for (int i = 0; i < 32; i++)
            begin
                if (x[i])
                    n = i + 1;
            end
            return n;
        endfunction

        function void push_word(logic [WORD_W-1:0] w, logic err);
            edp_pkg::res_item_t r;
            r.word  = w;
            r.last  = 1'b0;
            r.error = err;
            expected_words = {expected_words, r};
        endfunction

        // Appends the low n bits of bits, most significant first. A full store is
        // only emitted once another bit has to go in.
        function void append_bits(logic [31:0] bits, int unsigned n);
            for (int i = int'(n) - 1; i >= 0; i--)
            begin
                if (store_count == WORD_W)
                begin
                    push_word(store_bits, 1'b0);
                    store_bits  = '0;
                    store_count = 0;
                end
                store_bits  = {store_bits[WORD_W-2:0], bits[i]};
                store_count = store_count + 1;
            end
        endfunction

        function void predict_request(edp_pkg::req_item_t rq);
            int unsigned        start_n;
            int unsigned        nb;
            int unsigned        len_bits;
            int unsigned        raw_n;
            int unsigned        tail_idx;
            logic [31:0]        code_val;
            edp_pkg::res_item_t tail;
            start_n = expected_words.size();
            case (rq.command)
                edp_pkg::CMD_ENCODE:
                begin
                    encode_count++;
                    if (rq.value == '1)
                        push_word('0, 1'b1);
                    else
                    begin
                        code_val = rq.value + 32'd1;
                        nb       = bit_len(code_val);
                        len_bits = bit_len(nb);
                        append_bits('0, len_bits - 1);
                        append_bits(nb, len_bits);
                        append_bits(code_val, nb - 1);
                    end
                end
                edp_pkg::CMD_RAW:
                begin
                    raw_count++;
                    raw_n = (rq.bit_count > edp_pkg::RAW_MAX_BITS)
                          ? 32'(edp_pkg::RAW_MAX_BITS) : 32'(rq.bit_count);
                    append_bits(rq.value, raw_n);
                end
                edp_pkg::CMD_FLUSH:
                begin
                    flush_count++;
                    if (store_count > 0)
                    begin
                        push_word(store_bits << (WORD_W - store_count), 1'b0);
                        store_bits  = '0;
                        store_count = 0;
                    end
                end
                default:
                    ignored_count++;
            endcase
            if (expected_words.size() > start_n)
            begin
                tail_idx                 = expected_words.size() - 1;
                tail                     = expected_words[tail_idx];
                tail.last                = 1'b1;
                expected_words[tail_idx] = tail;
            end
        endfunction

        function void report(string what, logic [31:0] exp_v, logic [31:0] act_v);
            mismatches++;
            $display("%0t: %s: expected %h, actual %h", $time, what, exp_v, act_v);
        endfunction

        function void check_result(edp_pkg::res_item_t got);
            edp_pkg::res_item_t exp_r;
            if (expected_words.size() == 0)
            begin
                report("result with nothing expected", '0, got.word);
                return;
            end
            exp_r = expected_words.pop_front();
            if (got.word !== exp_r.word)
                report("word mismatch", exp_r.word, got.word);
            if (got.last !== exp_r.last)
                report("last mismatch", 32'(exp_r.last), 32'(got.last));
            if (got.error !== exp_r.error)
                report("error mismatch", 32'(exp_r.error), 32'(got.error));
            if (exp_r.error)
                overflows_checked++;
            else
                words_checked++;
        endfunction
    endclass

    logic               clk;
    logic               rst_n;
    logic               cmd_valid;
    logic               cmd_stall;
    edp_pkg::req_item_t cmd;
    logic               res_valid;
    logic               res_stall;
    edp_pkg::res_item_t res;

    // Both sides idle at random unless calm is set. Each increment of
    // hold_requests makes the result side stall once for a long stretch.
    logic      calm;
    int        hold_requests;
    int        cycle_count;

    word_scoreboard words_sb;

    elias_delta_bit_packer_top u_top
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd_valid (cmd_valid),
        .cmd_stall (cmd_stall),
        .cmd       (cmd),
        .res_valid (res_valid),
        .res_stall (res_stall),
        .res       (res)
    );

    // 10 ns clock, low first so that it is known from time zero.
    always
    begin
        clk = 1'b0;
        #5;
        clk = 1'b1;
        #5;
    end

    initial
    begin
        cycle_count = 0;
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
    end

    // Watchdog: a run that hangs on a handshake or leaves results missing ends here.
    initial
    begin
        while (cycle_count < CYCLE_LIMIT)
            @(posedge clk);
        $display("Timeout after %0d cycles with %0d results still expected.",
                 cycle_count, words_sb.expected_words.size());
        $display("DONE: errors detected");
        $finish;
    end

    // Both handshakes are observed at the rising edge. Inputs only change at the
    // falling edge, so the values seen here are the ones the block sampled.
    // A request accepted at this edge cannot have produced a result at the
    // same edge, so predicting first is safe.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (cmd_valid && !cmd_stall)
                words_sb.predict_request(cmd);
            if (res_valid && !res_stall)
                words_sb.check_result(res);
        end
    end

    // Result side stall generator. Most of the time the stall is short or absent,
    // now and then a long stall is drawn, and on request it holds off so that the
    // block backs up into its request side.
    initial
    begin
        int stall_left;
        int hold_served;
        stall_left  = 0;
        hold_served = 0;
        res_stall   = 1'b0;
        forever
        begin
            @(negedge clk);
            if (hold_requests != hold_served)
            begin
                hold_served = hold_requests;
                res_stall   = 1'b1;
                repeat (HOLD_CYCLES - 1)
                    @(negedge clk);
                res_stall  = 1'b0;
                stall_left = 0;
            end
            else if (calm)
                res_stall = 1'b0;
            else if (stall_left > 0)
            begin
                stall_left--;
                res_stall = 1'b1;
            end
            else if ($urandom_range(0, 99) < 30)
            begin
                if ($urandom_range(0, 19) == 0)
                    stall_left = $urandom_range(15, 60);
                else
                    stall_left = $urandom_range(0, 3);
                res_stall = 1'b1;
            end
            else
                res_stall = 1'b0;
        end
    end

    // Presents one request and returns once the block has taken it. Valid stays
    // high into the next request when no gap follows.
    task automatic drive_request(input edp_pkg::req_item_t rq);
        @(negedge clk);
        cmd_valid = 1'b1;
        cmd       = rq;
        @(posedge clk);
        while (cmd_stall)
            @(posedge clk);
    endtask

    // Random gap between requests: usually none, sometimes short, rarely long.
    // The payload is scrambled while valid is low.
    task automatic pause_requester();
        int pick;
        int gap;
        pick = $urandom_range(0, 99);
        if (calm || pick < 60)
            gap = 0;
        else if (pick < 92)
            gap = $urandom_range(1, 3);
        else
            gap = $urandom_range(10, 40);
        if (gap > 0)
        begin
            @(negedge clk);
            cmd_valid = 1'b0;
            cmd       = REQ_W'({$urandom, $urandom});
            repeat (gap - 1)
                @(negedge clk);
        end
    endtask

    task automatic send(input logic [1:0] c, input logic [31:0] v, input logic [5:0] bc);
        edp_pkg::req_item_t rq;
        rq.command   = c;
        rq.value     = v;
        rq.bit_count = bc;
        drive_request(rq);
        pause_requester();
    endtask

    // Stops offering requests until every expected result has come out.
    task automatic drain_results();
        @(negedge clk);
        cmd_valid = 1'b0;
        while (words_sb.expected_words.size() != 0)
            @(negedge clk);
    endtask

    function automatic edp_pkg::req_item_t random_request();
        edp_pkg::req_item_t rq;
        int                 pick;
        int                 w;
        pick         = $urandom_range(0, 99);
        rq.value     = $urandom;
        rq.bit_count = 6'($urandom_range(0, 63));
        if (pick < 45)
        begin
            // Encode with a value of random magnitude, so that short and long
            // codes both show up, plus the top two values now and then.
            rq.command = edp_pkg::CMD_ENCODE;
            w = $urandom_range(0, 32);
            rq.value = (w == 0) ? 32'd0 : ($urandom >> (32 - w));
            if ($urandom_range(0, 49) == 0)
                rq.value = 32'hFFFF_FFFF;
            else if ($urandom_range(0, 49) == 0)
                rq.value = 32'hFFFF_FFFE;
        end
        else if (pick < 85)
        begin
            rq.command = edp_pkg::CMD_RAW;
            w = $urandom_range(0, 19);
            if (w == 0)
                rq.bit_count = 6'd0;
            else if (w == 1)
                rq.bit_count = 6'($urandom_range(33, 63));
            else if (w < 5)
                rq.bit_count = edp_pkg::RAW_MAX_BITS;
            else
                rq.bit_count = 6'($urandom_range(1, 32));
        end
        else if (pick < 95)
            rq.command = edp_pkg::CMD_FLUSH;
        else
            rq.command = edp_pkg::CMD_UNUSED;
        return rq;
    endfunction

    // Sends random requests until count of them have done real work; unused
    // commands and zero-length raw writes are sent but not counted.
    task automatic run_random(input int count);
        edp_pkg::req_item_t rq;
        int                 done_n;
        done_n = 0;
        while (done_n < count)
        begin
            rq = random_request();
            drive_request(rq);
            if (rq.command != edp_pkg::CMD_UNUSED
                && !(rq.command == edp_pkg::CMD_RAW && rq.bit_count == 0))
                done_n++;
            pause_requester();
        end
    endtask

    // Main sequence. Reset is applied once. A short directed part covers the field
    // extremes and the corner cases of the packer: the shortest and longest codes,
    // the overflow value on an empty and a busy store, a word that fills exactly
    // and is held, a flush of an empty store, the unused command, raw counts of
    // zero and above 32, and a 42-bit code that crosses two word boundaries.
    // Random phases follow with normal idling, a long result hold-off while
    // requests keep coming, a stretch without any idling, and a second hold-off.
    initial
    begin
        rst_n         = 1'b0;
        cmd_valid     = 1'b0;
        cmd           = '0;
        calm          = 1'b0;
        hold_requests = 0;
        words_sb      = new();
        repeat (3)
            @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        send(edp_pkg::CMD_ENCODE, 32'd0, 6'd0);
        send(edp_pkg::CMD_ENCODE, 32'd1, 6'd63);
        send(edp_pkg::CMD_ENCODE, 32'd2, 6'd5);
        send(edp_pkg::CMD_ENCODE, 32'hFFFF_FFFE, 6'd0);
        // Overflow while the store holds bits: the store must be left alone.
        send(edp_pkg::CMD_ENCODE, 32'hFFFF_FFFF, 6'd0);
        send(edp_pkg::CMD_FLUSH, 32'd0, 6'd0);
        send(edp_pkg::CMD_FLUSH, 32'hFFFF_FFFF, 6'd63);
        send(edp_pkg::CMD_ENCODE, 32'hFFFF_FFFF, 6'd63);
        // A word that fills exactly is held until the flush.
        send(edp_pkg::CMD_RAW, 32'hFFFF_FFFF, edp_pkg::RAW_MAX_BITS);
        send(edp_pkg::CMD_UNUSED, 32'hFFFF_FFFF, 6'd63);
        send(edp_pkg::CMD_FLUSH, 32'd0, 6'd0);
        // A full word goes out once one more bit arrives.
        send(edp_pkg::CMD_RAW, 32'hA5A5_A5A5, edp_pkg::RAW_MAX_BITS);
        send(edp_pkg::CMD_RAW, 32'd1, 6'd1);
        send(edp_pkg::CMD_RAW, 32'hFFFF_FFFF, 6'd0);
        send(edp_pkg::CMD_RAW, 32'h1234_5678, 6'd63);
        send(edp_pkg::CMD_RAW, 32'hDEAD_BEEF, 6'd33);
        // With 31 bits held, the longest code spills into two further words.
        send(edp_pkg::CMD_RAW, 32'h2AAA_AAAA, 6'd30);
        send(edp_pkg::CMD_ENCODE, 32'hFFFF_FFFE, 6'd0);
        send(edp_pkg::CMD_FLUSH, 32'd0, 6'd0);
        send(edp_pkg::CMD_ENCODE, 32'h7FFF_FFFF, 6'd0);
        send(edp_pkg::CMD_RAW, 32'd0, 6'd5);
        send(edp_pkg::CMD_FLUSH, 32'd0, 6'd0);
        send(edp_pkg::CMD_UNUSED, 32'd0, 6'd0);

        run_random(600);
        drain_results();

        // Long hold-off on the result side while requests keep coming back to
        // back, so that the work queue fills and the request side stalls.
        hold_requests = hold_requests + 1;
        calm          = 1'b1;
        run_random(60);
        calm = 1'b0;
        drain_results();

        calm = 1'b1;
        run_random(250);
        calm = 1'b0;

        run_random(300);
        hold_requests = hold_requests + 1;
        run_random(200);

        drain_results();
        repeat (DRAIN_CYCLES)
            @(posedge clk);

        $display("Covered %0d encode, %0d raw, %0d flush and %0d unused-command requests.",
                 words_sb.encode_count, words_sb.raw_count, words_sb.flush_count,
                 words_sb.ignored_count);
        $display("Checked %0d packed words and %0d overflow results under random stalls.",
                 words_sb.words_checked, words_sb.overflows_checked);
        if (words_sb.mismatches == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule
